@@ hdl/vltd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// vltd_pkg
// Shared types and constants for the varint length/type deframer.
// -----------------------------------------------------------------------------
package vltd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned MAXLEN_W = 16;
    localparam int unsigned GROUP_W  = 7;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned TDATA_W  = 2 * WORD_W + BYTE_W;
    localparam int unsigned TUSER_W  = KIND_W + 1;

    localparam logic [MAXLEN_W-1:0] MAX_PAYLOAD_RESET = 16'd1024;
    // fifth group of a varint; a set continuation bit here is an error
    localparam logic [IDX_W-1:0]    LAST_GROUP        = 3'd4;

    localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OVERSIZE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OVERLONG = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        logic [WORD_W-1:0] message_type;
        logic [WORD_W-1:0] frame_length;
        logic [BYTE_W-1:0] data_byte;
        logic              first_byte;
        logic              last_byte;
    } vltd_result_t;

endpackage : vltd_pkg
`default_nettype wire

@@ hdl/vltd_in_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// vltd_in_stage
// Input register for received bytes; frees itself as the parser takes a byte.
// -----------------------------------------------------------------------------
module vltd_in_stage (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [vltd_pkg::BYTE_W-1:0] s_tdata,
    input  wire logic                      out_free,
    output logic                           take,
    output logic [vltd_pkg::BYTE_W-1:0]    byte_out
);
    import vltd_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    assign take     = valid_reg && out_free;
    assign s_tready = !valid_reg || take;
    assign byte_out = byte_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

endmodule : vltd_in_stage
`default_nettype wire

@@ hdl/vltd_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// vltd_parser
// Frame state machine: preamble hunt, two varints, payload count-down.
// -----------------------------------------------------------------------------
module vltd_parser (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [vltd_pkg::MAXLEN_W-1:0] cfg_wr_data,
    input  wire logic                          go,
    input  wire logic [vltd_pkg::BYTE_W-1:0]   rx_byte,
    output logic                               res_valid,
    output vltd_pkg::vltd_result_t             res
);
    import vltd_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN,
        PH_TYPE,
        PH_DATA
    } phase_t;

    phase_t              phase_reg,       phase_next;
    logic [WORD_W-1:0]   accum_reg,       accum_next;
    logic [IDX_W-1:0]    idx_reg,         idx_next;
    logic [WORD_W-1:0]   held_length_reg, held_length_next;
    logic [WORD_W-1:0]   held_type_reg,   held_type_next;
    logic [MAXLEN_W-1:0] bytes_left_reg,  bytes_left_next;
    logic                at_first_reg,    at_first_next;
    logic [MAXLEN_W-1:0] max_payload_reg;

    logic [WORD_W-1:0]   group_bits;
    logic [WORD_W-1:0]   accum_upd;
    logic                last_data;

    // place the 7-bit group; the fifth keeps only four bits
    always_comb begin
        unique case (idx_reg)
            3'd0:    group_bits = {25'd0, rx_byte[GROUP_W-1:0]};
            3'd1:    group_bits = {18'd0, rx_byte[GROUP_W-1:0], 7'd0};
            3'd2:    group_bits = {11'd0, rx_byte[GROUP_W-1:0], 14'd0};
            3'd3:    group_bits = {4'd0, rx_byte[GROUP_W-1:0], 21'd0};
            3'd4:    group_bits = {rx_byte[3:0], 28'd0};
            default: group_bits = '0;
        endcase
    end

    assign accum_upd = accum_reg | group_bits;
    assign last_data = (bytes_left_reg <= 16'd1);

    always_comb begin
        phase_next       = phase_reg;
        accum_next       = accum_reg;
        idx_next         = idx_reg;
        held_length_next = held_length_reg;
        held_type_next   = held_type_reg;
        bytes_left_next  = bytes_left_reg;
        at_first_next    = at_first_reg;
        res_valid        = 1'b0;
        res              = '0;

        if (go) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (rx_byte == '0) begin
                        phase_next = PH_LEN;
                        accum_next = '0;
                        idx_next   = '0;
                    end
                end
                PH_DATA: begin
                    res_valid        = 1'b1;
                    res.event_kind   = KIND_PAYLOAD;
                    res.message_type = held_type_reg;
                    res.frame_length = held_length_reg;
                    res.data_byte    = rx_byte;
                    res.first_byte   = at_first_reg;
                    res.last_byte    = last_data;
                    at_first_next    = 1'b0;
                    bytes_left_next  = bytes_left_reg - 16'd1;
                    if (last_data) begin
                        phase_next = PH_HUNT;
                    end
                end
                default: begin
                    if (rx_byte[BYTE_W-1]) begin
                        if (idx_reg == LAST_GROUP) begin
                            // overlong varint: report and resynchronise
                            res_valid        = 1'b1;
                            res.event_kind   = KIND_OVERLONG;
                            res.frame_length = (phase_reg == PH_TYPE) ? held_length_reg : '0;
                            phase_next       = PH_HUNT;
                            accum_next       = '0;
                            idx_next         = '0;
                        end else begin
                            accum_next = accum_upd;
                            idx_next   = idx_reg + 3'd1;
                        end
                    end else if (phase_reg == PH_LEN) begin
                        held_length_next = accum_upd;
                        accum_next       = '0;
                        idx_next         = '0;
                        phase_next       = PH_TYPE;
                    end else begin
                        // header complete: check the declared length now
                        held_type_next = accum_upd;
                        accum_next     = '0;
                        idx_next       = '0;
                        if (held_length_reg > {16'd0, max_payload_reg}) begin
                            res_valid        = 1'b1;
                            res.event_kind   = KIND_OVERSIZE;
                            res.message_type = accum_upd;
                            res.frame_length = held_length_reg;
                            phase_next       = PH_HUNT;
                        end else if (held_length_reg == '0) begin
                            res_valid        = 1'b1;
                            res.event_kind   = KIND_EMPTY;
                            res.message_type = accum_upd;
                            res.last_byte    = 1'b1;
                            phase_next       = PH_HUNT;
                        end else begin
                            bytes_left_next = held_length_reg[MAXLEN_W-1:0];
                            at_first_next   = 1'b1;
                            phase_next      = PH_DATA;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HUNT;
            accum_reg       <= '0;
            idx_reg         <= '0;
            held_length_reg <= '0;
            held_type_reg   <= '0;
            bytes_left_reg  <= '0;
            at_first_reg    <= 1'b1;
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end else begin
            phase_reg       <= phase_next;
            accum_reg       <= accum_next;
            idx_reg         <= idx_next;
            held_length_reg <= held_length_next;
            held_type_reg   <= held_type_next;
            bytes_left_reg  <= bytes_left_next;
            at_first_reg    <= at_first_next;
            if (cfg_wr_en) begin
                max_payload_reg <= cfg_wr_data;
            end
        end
    end

endmodule : vltd_parser
`default_nettype wire

@@ hdl/vltd_out_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// vltd_out_stage
// Result register driving the master-side stream.
// -----------------------------------------------------------------------------
module vltd_out_stage (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         load,
    input  wire vltd_pkg::vltd_result_t       res,
    output logic                              out_free,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [vltd_pkg::TDATA_W-1:0]      m_tdata,
    output logic [vltd_pkg::TUSER_W-1:0]      m_tuser,
    output logic                              m_tlast
);
    import vltd_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    vltd_result_t res_reg;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {res_reg.data_byte, res_reg.frame_length, res_reg.message_type};
    assign m_tuser  = {res_reg.first_byte, res_reg.event_kind};
    assign m_tlast  = res_reg.last_byte;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // hold the result until the transfer completes
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule : vltd_out_stage
`default_nettype wire

@@ hdl/varint_length_type_deframer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// varint_length_type_deframer
// Splits a byte stream into zero-preambled frames with varint length and type.
//
//   channel  dir  signals                 contents (low bits first)
//   s_       in   tvalid tready tdata[7:0] rx_byte
//   m_       out  tvalid tready tdata[71:0] message_type, frame_length, data_byte
//                  tuser[2:0] tlast        tuser: event_kind, first_byte; tlast: last_byte
//   cfg_     in   wr_en wr_data[15:0]     max_payload
//
// One byte per cycle while the m_ side does not stall. A byte taken on s_ is
// registered in the input register and parsed out of it, and its result is
// registered in the result register, whose valid flag drives m_tvalid.
// Reset (aresetn low, synchronous) returns to preamble hunt, max_payload 1024.
// A stalled m_ side holds the result; one more byte waits in the input register.
// -----------------------------------------------------------------------------
module varint_length_type_deframer (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [vltd_pkg::BYTE_W-1:0]   s_tdata,   // rx_byte
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // message_type[31:0], frame_length[63:32], data_byte[71:64]
    output logic [vltd_pkg::TDATA_W-1:0]       m_tdata,
    output logic [vltd_pkg::TUSER_W-1:0]       m_tuser,   // event_kind[1:0], first_byte[2]
    output logic                               m_tlast,
    input  wire logic                          cfg_wr_en,
    input  wire logic [vltd_pkg::MAXLEN_W-1:0] cfg_wr_data
);
    import vltd_pkg::*;

    logic              take;
    logic              out_free;
    logic [BYTE_W-1:0] rx_byte;
    logic              res_valid;
    vltd_result_t      res;

    vltd_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .out_free (out_free),
        .take     (take),
        .byte_out (rx_byte)
    );

    vltd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .go          (take),
        .rx_byte     (rx_byte),
        .res_valid   (res_valid),
        .res         (res)
    );

    vltd_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (take && res_valid),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    // an empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with an empty result register");

    a_empty_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[KIND_W-1:0] == KIND_EMPTY)
            |-> (m_tlast && !m_tuser[KIND_W] && m_tdata[WORD_W +: WORD_W] == '0))
        else $error("empty-frame result with bad marks or length");

    a_error_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[KIND_W-1:0] == KIND_OVERSIZE
                   || m_tuser[KIND_W-1:0] == KIND_OVERLONG))
            |-> (!m_tlast && !m_tuser[KIND_W] && m_tdata[2*WORD_W +: BYTE_W] == '0))
        else $error("error result carries payload marks");

    a_overlong_type: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[KIND_W-1:0] == KIND_OVERLONG) |-> m_tdata[WORD_W-1:0] == '0)
        else $error("overlong varint result with nonzero type");
`endif

endmodule : varint_length_type_deframer
`default_nettype wire
